// File: sv/assert_macros.svh
// Assertion macros shared by the rate calculator RTL.
// No dependencies; simulation gets the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/wprc_pkg.sv
// Types, rate tables and divisor constants of the PHY rate calculator.
// Used by every module of the block; depends on nothing.
package wprc_pkg;

	typedef enum logic [2:0] {
		MODE_11B      = 3'd0,
		MODE_OFDM     = 3'd1,
		MODE_HT_MF    = 3'd2,
		MODE_HT_GF    = 3'd3,
		MODE_VHT      = 3'd4,
		MODE_HE_SU    = 3'd5,
		MODE_HE_ER_SU = 3'd6,
		MODE_INVALID  = 3'd7
	} phy_mode_t;

	// Symbol time plus guard interval, in tenths of a microsecond.
	typedef enum logic [2:0] {
		DIV_40  = 3'd0,
		DIV_36  = 3'd1,
		DIV_136 = 3'd2,
		DIV_144 = 3'd3,
		DIV_160 = 3'd4,
		DIV_132 = 3'd5
	} div_sel_t;

	// Input descriptor, phy_mode in the lowest bits.
	typedef struct packed {
		logic [1:0] gi_select;
		logic [2:0] stream_count;
		logic [5:0] mcs;
		logic [2:0] bandwidth;
		logic [2:0] phy_mode;
	} desc_t;

	// Decode result: bypass items carry the final rate in hundreds of kbps in base.
	typedef struct packed {
		logic       err;
		logic       bypass;
		logic [14:0] base;
		logic [2:0] mult;
		div_sel_t   div_sel;
	} dec_t;

	// Scaled numerator, already divided by four.
	typedef struct packed {
		logic        err;
		logic        bypass;
		logic [15:0] k;
		logic [20:0] n;
		div_sel_t    div_sel;
	} scl_t;

	// Rate in hundreds of kbps.
	typedef struct packed {
		logic        err;
		logic [15:0] k;
	} quo_t;

	localparam logic [14:0] LEG_B_K [0:3] = '{15'd10, 15'd20, 15'd55, 15'd110};

	localparam logic [14:0] LEG_OFDM_K [0:7] = '{
		15'd60, 15'd90, 15'd120, 15'd180, 15'd240, 15'd360, 15'd480, 15'd540
	};

	localparam logic [14:0] VHT_DBPS [0:3][0:15] = '{
		'{15'd26, 15'd52, 15'd78, 15'd104, 15'd156, 15'd208, 15'd234, 15'd260,
		  15'd312, 15'd347, 15'd390, 15'd430, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd54, 15'd108, 15'd162, 15'd216, 15'd324, 15'd432, 15'd486, 15'd540,
		  15'd648, 15'd720, 15'd810, 15'd900, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd117, 15'd234, 15'd351, 15'd468, 15'd702, 15'd936, 15'd1053, 15'd1170,
		  15'd1404, 15'd1560, 15'd1755, 15'd1950, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd234, 15'd468, 15'd702, 15'd936, 15'd1404, 15'd1872, 15'd2106, 15'd2340,
		  15'd2808, 15'd3120, 15'd3510, 15'd3900, 15'd0, 15'd0, 15'd0, 15'd0}
	};

	localparam logic [14:0] HE_DBPS [0:7][0:15] = '{
		'{15'd117, 15'd234, 15'd351, 15'd468, 15'd702, 15'd936, 15'd1053, 15'd1170,
		  15'd1404, 15'd1560, 15'd1755, 15'd1950, 15'd2106, 15'd2340, 15'd0, 15'd0},
		'{15'd234, 15'd468, 15'd702, 15'd936, 15'd1404, 15'd1872, 15'd2106, 15'd2340,
		  15'd2808, 15'd3120, 15'd3510, 15'd3900, 15'd4212, 15'd4680, 15'd0, 15'd0},
		'{15'd490, 15'd980, 15'd1470, 15'd1960, 15'd2940, 15'd3920, 15'd4410, 15'd4900,
		  15'd5880, 15'd6533, 15'd7350, 15'd8166, 15'd8820, 15'd9800, 15'd0, 15'd0},
		'{15'd980, 15'd1960, 15'd2940, 15'd3920, 15'd5880, 15'd7840, 15'd8820,
		  15'd9800, 15'd11760, 15'd13066, 15'd14700, 15'd16333, 15'd17640, 15'd19600,
		  15'd0, 15'd0},
		'{15'd12, 15'd24, 15'd36, 15'd48, 15'd72, 15'd96, 15'd108, 15'd120,
		  15'd144, 15'd160, 15'd180, 15'd200, 15'd216, 15'd240, 15'd0, 15'd0},
		'{15'd24, 15'd48, 15'd72, 15'd96, 15'd144, 15'd192, 15'd216, 15'd240,
		  15'd288, 15'd320, 15'd360, 15'd400, 15'd432, 15'd480, 15'd0, 15'd0},
		'{15'd51, 15'd102, 15'd153, 15'd204, 15'd306, 15'd408, 15'd459, 15'd510,
		  15'd612, 15'd680, 15'd765, 15'd850, 15'd918, 15'd1020, 15'd0, 15'd0},
		'{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0}
	};

	// Quarter of the divisor: every divisor is a multiple of four.
	function automatic logic [5:0] div_e(input div_sel_t sel);
		logic [5:0] e;
		case (sel)
			DIV_40:  e = 6'd10;
			DIV_36:  e = 6'd9;
			DIV_136: e = 6'd34;
			DIV_144: e = 6'd36;
			DIV_160: e = 6'd40;
			DIV_132: e = 6'd33;
			default: e = 6'd10;
		endcase
		return e;
	endfunction

	// floor(2^24 / e), undershoots the quotient by at most one for n below 2^21.
	function automatic logic [20:0] div_m(input div_sel_t sel);
		logic [20:0] m;
		case (sel)
			DIV_40:  m = 21'd1677721;
			DIV_36:  m = 21'd1864135;
			DIV_136: m = 21'd493447;
			DIV_144: m = 21'd466033;
			DIV_160: m = 21'd419430;
			DIV_132: m = 21'd508400;
			default: m = 21'd1677721;
		endcase
		return m;
	endfunction

endpackage

// File: sv/wprc_decode.sv
// Stage one: validates the descriptor and looks up rate tables and divisor.
// Depends on wprc_pkg.
module wprc_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wprc_pkg::desc_t  desc,
	output logic             out_valid,
	input  logic             out_ready,
	output wprc_pkg::dec_t   dec
);

	wprc_pkg::dec_t    dec_d;
	wprc_pkg::dec_t    dec_s1;
	logic              v_s1;
	logic              adv;
	wprc_pkg::phy_mode_t mode;
	logic [2:0]        he_bw;
	logic              nss_bad;

	assign mode    = wprc_pkg::phy_mode_t'(desc.phy_mode);
	assign nss_bad = (desc.stream_count == 3'd0) || (desc.stream_count > 3'd4);

	always_comb begin
		dec_d.err     = 1'b0;
		dec_d.bypass  = 1'b0;
		dec_d.base    = '0;
		dec_d.mult    = 3'd1;
		dec_d.div_sel = wprc_pkg::DIV_40;
		he_bw         = desc.bandwidth;
		case (mode)
			wprc_pkg::MODE_11B, wprc_pkg::MODE_OFDM: begin
				dec_d.bypass = 1'b1;
				// 11b index 4..7 falls through to the OFDM table
				if (mode == wprc_pkg::MODE_11B && desc.mcs <= 6'd3) begin
					dec_d.base = wprc_pkg::LEG_B_K[desc.mcs[1:0]];
				end else if (desc.mcs <= 6'd7) begin
					dec_d.base = wprc_pkg::LEG_OFDM_K[desc.mcs[2:0]];
				end else begin
					dec_d.err = 1'b1;
				end
			end
			wprc_pkg::MODE_HT_MF, wprc_pkg::MODE_HT_GF: begin
				if (desc.bandwidth >= 3'd2 || desc.mcs > 6'd31 || desc.gi_select[1]) begin
					dec_d.err = 1'b1;
				end else begin
					dec_d.base    = wprc_pkg::VHT_DBPS[{1'b0, desc.bandwidth[0]}]
						[{1'b0, desc.mcs[2:0]}];
					dec_d.mult    = {1'b0, desc.mcs[4:3]} + 3'd1;
					dec_d.div_sel = desc.gi_select[0] ? wprc_pkg::DIV_36 : wprc_pkg::DIV_40;
				end
			end
			wprc_pkg::MODE_VHT: begin
				if (desc.bandwidth[2] || desc.mcs >= 6'd12 || desc.gi_select[1] ||
					nss_bad) begin
					dec_d.err = 1'b1;
				end else begin
					dec_d.base    = wprc_pkg::VHT_DBPS[desc.bandwidth[1:0]][desc.mcs[3:0]];
					dec_d.mult    = desc.stream_count;
					dec_d.div_sel = desc.gi_select[0] ? wprc_pkg::DIV_36 : wprc_pkg::DIV_40;
				end
			end
			wprc_pkg::MODE_HE_SU, wprc_pkg::MODE_HE_ER_SU: begin
				if (desc.bandwidth == 3'd7 || desc.mcs >= 6'd14 || nss_bad) begin
					dec_d.err = 1'b1;
				end else begin
					// ER SU: bandwidth 1 means the 106-tone RU
					if (mode == wprc_pkg::MODE_HE_ER_SU && desc.bandwidth == 3'd1) begin
						he_bw = 3'd6;
					end
					dec_d.base = wprc_pkg::HE_DBPS[he_bw][desc.mcs[3:0]];
					dec_d.mult = desc.stream_count;
					case (desc.gi_select)
						2'd0:    dec_d.div_sel = wprc_pkg::DIV_136;
						2'd1:    dec_d.div_sel = wprc_pkg::DIV_144;
						2'd2:    dec_d.div_sel = wprc_pkg::DIV_160;
						default: dec_d.div_sel = wprc_pkg::DIV_132;
					endcase
				end
			end
			default: begin
				dec_d.err = 1'b1;
			end
		endcase
		// errors ride the bypass path with a zero rate
		if (dec_d.err) begin
			dec_d.bypass = 1'b1;
			dec_d.base   = '0;
		end
	end

	assign adv      = !v_s1 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			dec_s1 <= dec_d;
		end
	end

	assign out_valid = v_s1;
	assign dec       = dec_s1;

endmodule

// File: sv/wprc_scale.sv
// Stage two: bits per symbol times streams times 100, plus half the divisor.
// Depends on wprc_pkg; feeds the divider.
module wprc_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wprc_pkg::dec_t  dec,
	output logic            out_valid,
	input  logic            out_ready,
	output wprc_pkg::scl_t  scl
);

	wprc_pkg::scl_t scl_d;
	wprc_pkg::scl_t scl_s2;
	logic           v_s2;
	logic           adv;
	logic [8:0]     mult100;
	logic [23:0]    prod;
	logic [23:0]    sum;

	// q/100 rounded equals (100*dbps + d/2) / d; d = 4e, so drop two bits first
	always_comb begin
		mult100       = 9'(dec.mult) * 9'd100;
		prod          = 24'(dec.base) * 24'(mult100);
		sum           = prod + 24'({wprc_pkg::div_e(dec.div_sel), 1'b0});
		scl_d.err     = dec.err;
		scl_d.bypass  = dec.bypass;
		scl_d.k       = 16'(dec.base);
		scl_d.n       = sum[22:2];
		scl_d.div_sel = dec.div_sel;
	end

	assign adv      = !v_s2 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			scl_s2 <= scl_d;
		end
	end

	assign out_valid = v_s2;
	assign scl       = scl_s2;

endmodule

// File: sv/wprc_div.sv
// Stages three and four: constant divide by reciprocal multiply and one correction.
// Depends on wprc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wprc_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wprc_pkg::scl_t  scl,
	output logic            out_valid,
	input  logic            out_ready,
	output wprc_pkg::quo_t  quo
);

	logic [41:0]        p;
	logic [15:0]        qe_d;
	logic               v_s3;
	logic               err_s3;
	logic               bypass_s3;
	logic [15:0]        qe_s3;
	logic [20:0]        n_s3;
	wprc_pkg::div_sel_t sel_s3;
	logic               adv3;
	logic [5:0]         e3;
	logic [21:0]        qe_mul;
	logic [21:0]        rem;
	logic               inc;
	logic               v_s4;
	wprc_pkg::quo_t     quo_s4;
	logic               adv4;

	// stage three: estimate, low by at most one
	always_comb begin
		p    = 42'(scl.n) * 42'(wprc_pkg::div_m(scl.div_sel));
		qe_d = scl.bypass ? scl.k : p[39:24];
	end

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign in_ready = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && in_valid) begin
			err_s3    <= scl.err;
			bypass_s3 <= scl.bypass;
			qe_s3     <= qe_d;
			n_s3      <= scl.n;
			sel_s3    <= scl.div_sel;
		end
	end

	// stage four: bump the estimate when the remainder reaches the divisor
	always_comb begin
		e3     = wprc_pkg::div_e(sel_s3);
		qe_mul = 22'(qe_s3) * 22'(e3);
		rem    = 22'(n_s3) - qe_mul;
		inc    = !bypass_s3 && (rem >= 22'(e3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			quo_s4.err <= err_s3;
			quo_s4.k   <= qe_s3 + 16'(inc);
		end
	end

	assign out_valid = v_s4;
	assign quo       = quo_s4;

	`ASSERT_IMPLY(a_rem_bound, clk, arst_n, v_s3 && !bypass_s3, rem < 22'({e3, 1'b0}))
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, v_s4 && quo_s4.err, quo_s4.k == 16'd0)

endmodule

// File: sv/wlan_phy_rate_kbps_calc.sv
// Top level of the PHY data-rate calculator.
// Depends on wprc_pkg, wprc_decode, wprc_scale, wprc_div and assert_macros.svh.
`include "assert_macros.svh"

// Takes one frame rate descriptor per cycle while the output is not stalled and
// returns its data rate in kbps, rounded to hundreds, with an error flag; an
// invalid descriptor gives zero and the flag. Five register stages (table decode,
// scaling multiply, reciprocal multiply, remainder correction, output register)
// sit between the input transfer and the result. Back-pressure on the output
// stalls the whole pipeline; bubbles are squeezed out, so the input keeps taking
// items until all five stages hold one.
module wlan_phy_rate_kbps_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] phy_mode, [5:3] bandwidth, [11:6] mcs, [14:12] stream_count,
	// [16:15] gi_select, [23:17] zero
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [22:0] data rate in kbps, [23] zero
	output logic [23:0] m_axis_tdata,
	// [0] rate_error
	output logic [0:0]  m_axis_tuser
);

	wprc_pkg::desc_t desc;
	wprc_pkg::dec_t  dec;
	wprc_pkg::scl_t  scl;
	wprc_pkg::quo_t  quo;
	logic            dec_valid;
	logic            dec_ready;
	logic            scl_valid;
	logic            scl_ready;
	logic            quo_valid;
	logic            quo_ready;
	logic            out_valid_q;
	logic [22:0]     rate_q;
	logic            err_q;

	assign desc = s_axis_tdata[16:0];

	wprc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.desc      (desc),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.dec       (dec)
	);

	wprc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.dec       (dec),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.scl       (scl)
	);

	wprc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.scl       (scl),
		.out_valid (quo_valid),
		.out_ready (quo_ready),
		.quo       (quo)
	);

	// output register: hold while the result waits for its transfer
	assign quo_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (quo_ready) begin
			out_valid_q <= quo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (quo_ready && quo_valid) begin
			rate_q <= 23'(quo.k) * 23'd100;
			err_q  <= quo.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, rate_q};
	assign m_axis_tuser  = err_q;

	`ASSERT_IMPLY(a_err_rate_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata == 24'd0)
	`ASSERT_IMPLY(a_stall_only_full, clk, arst_n, !s_axis_tready,
		m_axis_tvalid && !m_axis_tready)

endmodule
